### rtl/itrd_pkg.sv
// Shared types and constants for the signed integer to radix digit converter.
`default_nettype none
package itrd_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned NIBBLES   = VALUE_W / DIGIT_W;
  localparam int unsigned MAX_NDIG  = 32;
  localparam int unsigned NDIG_W    = 6;
  localparam int unsigned ALPHA_SLOTS = 16;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI  = 2'd2;

  localparam logic [4:0]  RST_ALPHA_LEN = 5'd10;
  localparam logic [63:0] RST_ALPHA_LO  = 64'h3736353433323130;
  localparam logic [63:0] RST_ALPHA_HI  = 64'h0;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // One divide step: four quotient bits against a small radix.
  typedef struct packed {
    logic [DIGIT_W-1:0] rem;
    logic [DIGIT_W-1:0] nib;
    logic [RADIX_W-1:0] radix;
  } div_req_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] quo;
    logic [DIGIT_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/itrd_divstep.sv
// Shared divide-step unit: one quotient nibble and running remainder per cycle.
`default_nettype none
module itrd_divstep (
  input  itrd_pkg::div_req_t req,
  output itrd_pkg::div_rsp_t rsp
);
  import itrd_pkg::*;

  logic [RADIX_W-1:0] part;
  logic [DIGIT_W-1:0] qbits;

  always_comb begin
    part  = {1'b0, req.rem};
    qbits = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      part = {part[RADIX_W-2:0], req.nib[b]};
      if (part >= req.radix) begin
        part     = part - req.radix;
        qbits[b] = 1'b1;
      end
    end
    rsp.quo = qbits;
    rsp.rem = part[DIGIT_W-1:0];
  end

endmodule
`default_nettype wire

### rtl/itrd_cfg.sv
// Alphabet registers, alphabet check and digit character lookup.
`default_nettype none
module itrd_cfg #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [itrd_pkg::DIGIT_W-1:0]      dig_idx,
  output logic [itrd_pkg::CHAR_W-1:0]       dig_char,
  output logic [itrd_pkg::RADIX_W-1:0]      radix
);
  import itrd_pkg::*;

  localparam logic [RADIX_W-1:0] LEN_CAP = RADIX_W'(MAX_DIGITS);

  logic [4:0]  alpha_len_r;
  logic [63:0] alpha_lo_r;
  logic [63:0] alpha_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_len_r <= RST_ALPHA_LEN;
      alpha_lo_r  <= RST_ALPHA_LO;
      alpha_hi_r  <= RST_ALPHA_HI;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALPHA_LEN: alpha_len_r <= cfg_data[4:0];
        CFG_ALPHA_LO:  alpha_lo_r  <= cfg_data;
        CFG_ALPHA_HI:  alpha_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2*64-1:0]            alpha_all;
  logic [CHAR_W-1:0]          ch [ALPHA_SLOTS];
  logic [RADIX_W-1:0]         len_cap;
  logic [RADIX_W-1:0]         n_used;
  logic [ALPHA_SLOTS-1:0]     used;
  logic                       bad;

  assign alpha_all = {alpha_hi_r, alpha_lo_r};
  assign dig_char  = alpha_all[dig_idx*CHAR_W +: CHAR_W];

  always_comb begin
    len_cap = (alpha_len_r > LEN_CAP) ? LEN_CAP : alpha_len_r;
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      ch[i] = alpha_all[i*CHAR_W +: CHAR_W];
    end
    // first zero byte inside the configured length ends the alphabet
    n_used = len_cap;
    for (int i = ALPHA_SLOTS - 1; i >= 0; i--) begin
      if ((RADIX_W'(i) < len_cap) && (ch[i] == '0)) n_used = RADIX_W'(i);
    end
    bad = 1'b0;
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      used[i] = RADIX_W'(i) < n_used;
      if (used[i] && (((ch[i] >= CH_TAB) && (ch[i] <= CH_CR)) || (ch[i] == CH_SPACE) ||
                      (ch[i] == CH_PLUS) || (ch[i] == CH_MINUS))) bad = 1'b1;
    end
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
        if (used[j] && (ch[i] == ch[j])) bad = 1'b1;
      end
    end
    radix = ((n_used >= RADIX_W'(2)) && !bad) ? n_used : '0;
  end

endmodule
`default_nettype wire

### rtl/signed_integer_to_radix_digits.sv
// Top level: converts a signed 32-bit value into radix digit characters.
//
// Usage:
//  - Input channel in_valid/in_stall/in_value. A transaction is taken when
//    in_valid is high and in_stall is low; in_stall is high while a value is
//    being converted.
//  - Result channel out_valid/out_stall/out_character/out_last, one
//    transaction per character, '-' first for negative values, most
//    significant digit next, out_last on the final character.
//  - Config channel cfg_valid/cfg_ready/cfg_index/cfg_data, always ready.
//    Write only while idle. Index 0 alphabet length, 1 and 2 the alphabet.
//  - Order: an alphabet check, then each digit in the shared divide-step
//    unit (one quotient nibble per cycle), then the characters out, each
//    held while out_stall is high.
//  - An invalid alphabet drops the value with no output after the check cycle.
//  - Reset empties the output register and restores the base 8 alphabet.
//  - A stall on the result side holds the current character; the final
//    character may still wait while the next value is taken in.
`default_nettype none
module signed_integer_to_radix_digits #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [31:0]               in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_character,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import itrd_pkg::*;

  state_t              state_r, state_nxt;
  logic                neg_r, neg_nxt;
  logic [VALUE_W-1:0]  quo_r, quo_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [NDIG_W-1:0]   nd_r, nd_nxt;
  logic [DIGIT_W-1:0]  dig_buf_r [MAX_NDIG];
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic                buf_we;
  logic [NDIG_W-1:0]   nd_dec;
  logic [DIGIT_W-1:0]  dig_idx;
  logic [CHAR_W-1:0]   dig_char;
  logic [RADIX_W-1:0]  cfg_radix;
  logic                out_free;
  logic                in_take;
  logic [VALUE_W-1:0]  quo_shift;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign cfg_ready = 1'b1;

  itrd_cfg #(.MAX_DIGITS(MAX_DIGITS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .dig_idx  (dig_idx),
    .dig_char (dig_char),
    .radix    (cfg_radix)
  );

  assign div_req.rem   = rem_r;
  assign div_req.nib   = quo_r[VALUE_W-1 -: DIGIT_W];
  assign div_req.radix = radix_r;

  itrd_divstep u_div (
    .req(div_req),
    .rsp(div_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign nd_dec    = nd_r - NDIG_W'(1);
  assign dig_idx   = dig_buf_r[nd_dec[4:0]];
  assign quo_shift = {quo_r[VALUE_W-DIGIT_W-1:0], div_rsp.quo};

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    step_nxt      = step_r;
    nd_nxt        = nd_r;
    buf_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          neg_nxt   = in_value[31];
          quo_nxt   = in_value[31] ? (~in_value + 32'd1) : in_value;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        radix_nxt = cfg_radix;
        rem_nxt   = '0;
        step_nxt  = '0;
        nd_nxt    = '0;
        state_nxt = (cfg_radix == '0) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        quo_nxt  = quo_shift;
        rem_nxt  = div_rsp.rem;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(NIBBLES - 1)) begin
          buf_we  = 1'b1;
          nd_nxt  = nd_r + NDIG_W'(1);
          rem_nxt = '0;
          if ((quo_shift == '0) || (nd_r == NDIG_W'(MAX_NDIG - 1))) begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = dig_char;
          out_last_nxt  = (nd_r == NDIG_W'(1));
          nd_nxt        = nd_dec;
          if (nd_r == NDIG_W'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    step_r     <= step_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (buf_we) dig_buf_r[nd_r[4:0]] <= div_rsp.rem;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_take_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_CHECK)
    else $error("accepted value did not go to the alphabet check");

  a_div_radix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> (radix_r >= RADIX_W'(2)) && ({1'b0, rem_r} < radix_r))
    else $error("divide step running with a bad radix or remainder");

  a_emit_nd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_SIGN) |-> (nd_r != '0) &&
    (nd_r <= NDIG_W'(MAX_NDIG)))
    else $error("digit count out of range while emitting");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && nd_r == NDIG_W'(1)) |=>
    (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("final digit did not close the transaction");

endmodule
`default_nettype wire
